>>> hdl/rtp_nalu_packetizer_unit_assert.svh
// assertion macros for the rtp nalu packetizer
// no dependencies; included by the top level
`ifndef RTP_NALU_PACKETIZER_UNIT_ASSERT_SVH
`define RTP_NALU_PACKETIZER_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define RNP_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rnp check failed");

// next-cycle implication, held off during reset
`define RNP_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rnp check failed");

`endif

>>> hdl/rnp_pkg.sv
// shared types and constants of the rtp nalu packetizer
// no dependencies; used by every module of the block
package rnp_pkg;

  // codec modes as latched per unit
  localparam logic [1:0] MODE_H264  = 2'd0;
  localparam logic [1:0] MODE_H265  = 2'd1;
  localparam logic [1:0] MODE_AUDIO = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CODEC_MODE = 2'd0;
  localparam logic [1:0] REG_PTYPE      = 2'd1;
  localparam logic [1:0] REG_SOURCE_ID  = 2'd2;
  localparam logic [1:0] REG_MTU        = 2'd3;

  // register reset values
  localparam logic [1:0]  CODEC_MODE_RST = MODE_H264;
  localparam logic [6:0]  PTYPE_RST      = 7'd96;
  localparam logic [31:0] SOURCE_ID_RST  = 32'd0;
  localparam logic [14:0] MTU_RST        = 15'd1400;
  localparam logic [14:0] MIN_PAYLOAD    = 15'd16;

  // rtp header and fu constants
  localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
  localparam logic [15:0] RTP_HDR_BYTES    = 16'd12;
  localparam logic [7:0]  FU_A_TYPE        = 8'd28;
  localparam logic [7:0]  FU_H265_TYPE_SH  = 8'h62;  // type 49 shifted left by one
  localparam logic [7:0]  FU_START_BIT     = 8'h80;
  localparam logic [7:0]  FU_END_BIT       = 8'h40;

  // byte position within an expanded command
  localparam int unsigned RNP_IDX_W   = 5;
  localparam logic [RNP_IDX_W-1:0] FRAME_HDR_LEN = 5'd14;

  // queue sizing
  localparam int unsigned RNP_QUEUE_DEPTH = 4;

  // one command from the front to the back part
  typedef struct packed {
    logic        has_head;
    logic        marker;
    logic [15:0] rtp_len;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [1:0]  fu_cnt;
    logic [7:0]  fu0;
    logic [7:0]  fu1;
    logic [7:0]  fu2;
    logic [7:0]  data;
    logic        pkt_end;
  } rnp_cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } rnp_qstat_t;

endpackage

>>> hdl/rnp_if.sv
// valid/ready channel interfaces for the rtp nalu packetizer
// no dependencies
interface rnp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        unit_first;
  logic [15:0] unit_length;
  logic [31:0] media_time;

  modport source (output valid, data_byte, unit_first, unit_length, media_time,
                  input ready);
  modport sink (input valid, data_byte, unit_first, unit_length, media_time,
                output ready);
endinterface

interface rnp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_start;
  logic       packet_end;
  logic       run_last;

  modport source (output valid, out_byte, packet_start, packet_end, run_last,
                  input ready);
  modport sink (input valid, out_byte, packet_start, packet_end, run_last,
                output ready);
endinterface

>>> hdl/rnp_front.sv
// front part: accepts input bytes, tracks unit/fragment state, issues commands
// depends on rnp_pkg and rnp_in_if
module rnp_front
  import rnp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  rnp_in_if.sink         in_i,
  input  logic [1:0]     codec_mode_i,
  input  logic [14:0]    mtu_i,
  input  rnp_qstat_t     qstat_i,
  output logic           push_o,
  output rnp_cmd_t       cmd_o
);

  logic [15:0] seq_q, seq_d;
  logic [15:0] held_hdr_q, held_hdr_d;
  logic [31:0] held_time_q, held_time_d;
  logic [15:0] unit_rem_q, unit_rem_d;
  logic [15:0] frag_rem_q, frag_rem_d;
  logic        fragmenting_q, fragmenting_d;
  logic        first_frag_q, first_frag_d;
  logic [1:0]  unit_mode_q, unit_mode_d;
  logic [15:0] frag_max_q, frag_max_d;
  logic        hdr_pend_q, hdr_pend_d;

  logic        accept;
  logic [1:0]  mode_in;
  logic [14:0] mp;
  logic [15:0] frag;
  logic        frag_last;
  logic [7:0]  h0;
  logic [7:0]  fu_bits;

  assign in_i.ready = !qstat_i.full;
  assign accept     = in_i.valid && !qstat_i.full;

  // mode and payload limit as latched on a first byte
  assign mode_in = (codec_mode_i >= MODE_AUDIO) ? MODE_AUDIO : codec_mode_i;
  assign mp      = (mtu_i < MIN_PAYLOAD) ? MIN_PAYLOAD : mtu_i;

  // size and flags of a fragment opened by this byte
  assign frag      = (unit_rem_q < frag_max_q) ? unit_rem_q : frag_max_q;
  assign frag_last = (frag == unit_rem_q);
  assign h0        = held_hdr_q[15:8];
  assign fu_bits   = (first_frag_q ? FU_START_BIT : 8'h00) | (frag_last ? FU_END_BIT : 8'h00);

  // unit state update and command build
  always_comb begin
    seq_d         = seq_q;
    held_hdr_d    = held_hdr_q;
    held_time_d   = held_time_q;
    unit_rem_d    = unit_rem_q;
    frag_rem_d    = frag_rem_q;
    fragmenting_d = fragmenting_q;
    first_frag_d  = first_frag_q;
    unit_mode_d   = unit_mode_q;
    frag_max_d    = frag_max_q;
    hdr_pend_d    = hdr_pend_q;
    push_o        = 1'b0;
    cmd_o         = '0;
    cmd_o.data    = in_i.data_byte;
    cmd_o.seq     = seq_q;
    cmd_o.ts      = held_time_q;

    if (accept) begin
      if (in_i.unit_first) begin
        frag_rem_d    = '0;
        fragmenting_d = 1'b0;
        hdr_pend_d    = 1'b0;
        first_frag_d  = 1'b1;
        if (in_i.unit_length == 16'd0 ||
            (mode_in == MODE_H265 && in_i.unit_length < 16'd2)) begin
          // short unit is dropped
          unit_rem_d = '0;
        end else begin
          unit_mode_d = mode_in;
          held_time_d = in_i.media_time;
          unit_rem_d  = in_i.unit_length - 16'd1;
          if (mode_in == MODE_AUDIO || in_i.unit_length <= {1'b0, mp}) begin
            // whole unit in one packet
            push_o         = 1'b1;
            cmd_o.has_head = 1'b1;
            cmd_o.marker   = 1'b1;
            cmd_o.rtp_len  = RTP_HDR_BYTES + in_i.unit_length;
            cmd_o.ts       = in_i.media_time;
            cmd_o.pkt_end  = (in_i.unit_length == 16'd1);
            seq_d          = seq_q + 16'd1;
          end else begin
            fragmenting_d = 1'b1;
            held_hdr_d    = {in_i.data_byte, 8'h00};
            hdr_pend_d    = (mode_in == MODE_H265);
            frag_max_d    = {1'b0, mp} - ((mode_in == MODE_H265) ? 16'd3 : 16'd2);
          end
        end
      end else if (unit_rem_q != 16'd0) begin
        unit_rem_d = unit_rem_q - 16'd1;
        if (!fragmenting_q) begin
          // payload byte of a whole packet
          push_o        = 1'b1;
          cmd_o.pkt_end = (unit_rem_q == 16'd1);
        end else if (hdr_pend_q) begin
          // second header byte of an h265 unit
          held_hdr_d = {held_hdr_q[15:8], in_i.data_byte};
          hdr_pend_d = 1'b0;
        end else if (frag_rem_q == 16'd0) begin
          // first byte of a new fragment opens a packet
          push_o         = 1'b1;
          cmd_o.has_head = 1'b1;
          cmd_o.marker   = frag_last;
          if (unit_mode_q == MODE_H265) begin
            cmd_o.rtp_len = RTP_HDR_BYTES + 16'd3 + frag;
            cmd_o.fu_cnt  = 2'd3;
            cmd_o.fu0     = (h0 & 8'h81) | FU_H265_TYPE_SH;
            cmd_o.fu1     = held_hdr_q[7:0];
            cmd_o.fu2     = fu_bits | ((h0 >> 1) & 8'h3F);
          end else begin
            cmd_o.rtp_len = RTP_HDR_BYTES + 16'd2 + frag;
            cmd_o.fu_cnt  = 2'd2;
            cmd_o.fu0     = (h0 & 8'hE0) | FU_A_TYPE;
            cmd_o.fu1     = fu_bits | (h0 & 8'h1F);
          end
          cmd_o.pkt_end = (frag == 16'd1);
          first_frag_d  = 1'b0;
          frag_rem_d    = frag - 16'd1;
          seq_d         = seq_q + 16'd1;
        end else begin
          // continuing fragment payload
          push_o        = 1'b1;
          frag_rem_d    = frag_rem_q - 16'd1;
          cmd_o.pkt_end = (frag_rem_q == 16'd1);
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= '0;
      held_hdr_q    <= '0;
      held_time_q   <= '0;
      unit_rem_q    <= '0;
      frag_rem_q    <= '0;
      fragmenting_q <= 1'b0;
      first_frag_q  <= 1'b1;
      unit_mode_q   <= MODE_H264;
      frag_max_q    <= '0;
      hdr_pend_q    <= 1'b0;
    end else begin
      seq_q         <= seq_d;
      held_hdr_q    <= held_hdr_d;
      held_time_q   <= held_time_d;
      unit_rem_q    <= unit_rem_d;
      frag_rem_q    <= frag_rem_d;
      fragmenting_q <= fragmenting_d;
      first_frag_q  <= first_frag_d;
      unit_mode_q   <= unit_mode_d;
      frag_max_q    <= frag_max_d;
      hdr_pend_q    <= hdr_pend_d;
    end
  end

endmodule

>>> hdl/rnp_queue.sv
// command queue between the front and back parts
// depends on rnp_pkg
module rnp_queue
  import rnp_pkg::*;
#(
  parameter int unsigned DEPTH = RNP_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rnp_cmd_t   cmd_i,
  input  logic       pop_i,
  output rnp_cmd_t   head_o,
  output rnp_qstat_t qstat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rnp_cmd_t        slots_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign qstat_o.full  = (count_q == CW'(DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = slots_q[rd_ptr_q];

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/rnp_back.sv
// back part: expands commands into framed bytes through an output register
// depends on rnp_pkg and rnp_out_if
module rnp_back
  import rnp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rnp_cmd_t    head_i,
  input  rnp_qstat_t  qstat_i,
  input  logic [6:0]  ptype_i,
  input  logic [31:0] source_id_i,
  output logic        pop_o,
  rnp_out_if.source   out_o
);

  logic [RNP_IDX_W-1:0] idx_q, idx_d;
  logic [RNP_IDX_W-1:0] last_idx;
  logic                 out_valid_q;
  logic [7:0]           byte_q;
  logic                 start_q, end_q, run_last_q;
  logic                 load;
  logic                 at_last;
  logic [7:0]           byte_sel;

  assign last_idx = head_i.has_head ? FRAME_HDR_LEN + RNP_IDX_W'(head_i.fu_cnt) : '0;
  assign at_last  = (idx_q == last_idx);
  assign load     = !qstat_i.empty && (!out_valid_q || out_o.ready);
  assign pop_o    = load && at_last;
  assign idx_d    = load ? (at_last ? '0 : idx_q + 1'b1) : idx_q;

  // byte at the current position of the command
  always_comb begin
    if (at_last) begin
      byte_sel = head_i.data;
    end else begin
      case (idx_q)
        5'd0:    byte_sel = head_i.rtp_len[15:8];
        5'd1:    byte_sel = head_i.rtp_len[7:0];
        5'd2:    byte_sel = RTP_VERSION_BYTE;
        5'd3:    byte_sel = {head_i.marker, ptype_i};
        5'd4:    byte_sel = head_i.seq[15:8];
        5'd5:    byte_sel = head_i.seq[7:0];
        5'd6:    byte_sel = head_i.ts[31:24];
        5'd7:    byte_sel = head_i.ts[23:16];
        5'd8:    byte_sel = head_i.ts[15:8];
        5'd9:    byte_sel = head_i.ts[7:0];
        5'd10:   byte_sel = source_id_i[31:24];
        5'd11:   byte_sel = source_id_i[23:16];
        5'd12:   byte_sel = source_id_i[15:8];
        5'd13:   byte_sel = source_id_i[7:0];
        5'd14:   byte_sel = head_i.fu0;
        5'd15:   byte_sel = head_i.fu1;
        5'd16:   byte_sel = head_i.fu2;
        default: byte_sel = head_i.data;
      endcase
    end
  end

  // position counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= byte_sel;
      start_q    <= head_i.has_head && (idx_q == '0);
      end_q      <= at_last && head_i.pkt_end;
      run_last_q <= at_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = byte_q;
  assign out_o.packet_start = start_q;
  assign out_o.packet_end   = end_q;
  assign out_o.run_last     = run_last_q;

endmodule

>>> hdl/rtp_nalu_packetizer_unit.sv
// top level of the rtp nalu packetizer: config registers, front, queue, back
// depends on rnp_pkg, rnp_if, rnp_front, rnp_queue, rnp_back and the assert header
//
// Input channel in_i takes one unit byte per transfer; unit_first marks the first
// byte, which also carries unit_length and media_time. Output channel out_o gives
// the rtp-over-tcp byte stream, one byte per transfer, with packet_start on the
// first length byte, packet_end on the last payload byte and run_last on the last
// byte caused by an input transfer. Registers are written over the apb port at
// byte addresses 0, 4, 8 and 12 (codec mode, payload type, source id, size limit).
// The first output byte of a transfer passes through the command queue and the
// output register before it is valid; a busy queue or a stalled receiver delays it.
// Throughput: while the receiver stays ready, payload bytes go out one per cycle;
// a byte that opens a packet expands to 15 bytes (whole unit), 17 (h264 fragment)
// or 18 (h265 fragment), emitted by the back part one per cycle. A command queue
// of QUEUE_DEPTH entries lets input continue while a header burst drains; input
// stalls when it fills. Reset clears all unit state, the sequence number and the
// queue and loads the register defaults. A stalled receiver holds the output
// byte and backs up the queue, and then the input.
`include "rtp_nalu_packetizer_unit_assert.svh"

module rtp_nalu_packetizer_unit
  import rnp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = RNP_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rnp_in_if.sink      in_i,
  rnp_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  codec_mode_q;
  logic [6:0]  ptype_q;
  logic [31:0] source_id_q;
  logic [14:0] mtu_q;
  logic        cfg_wr;

  logic        push;
  logic        pop;
  rnp_cmd_t    cmd;
  rnp_cmd_t    head;
  rnp_qstat_t  qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_mode_q <= CODEC_MODE_RST;
      ptype_q      <= PTYPE_RST;
      source_id_q  <= SOURCE_ID_RST;
      mtu_q        <= MTU_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CODEC_MODE: codec_mode_q <= pwdata[1:0];
        REG_PTYPE:      ptype_q      <= pwdata[6:0];
        REG_SOURCE_ID:  source_id_q  <= pwdata;
        REG_MTU:        mtu_q        <= pwdata[14:0];
        default:        ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_CODEC_MODE: prdata = {30'd0, codec_mode_q};
      REG_PTYPE:      prdata = {25'd0, ptype_q};
      REG_SOURCE_ID:  prdata = source_id_q;
      REG_MTU:        prdata = {17'd0, mtu_q};
      default:        prdata = '0;
    endcase
  end

  rnp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .codec_mode_i (codec_mode_q),
    .mtu_i        (mtu_q),
    .qstat_i      (qstat),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  rnp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  rnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .ptype_i     (ptype_q),
    .source_id_i (source_id_q),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  // checks on the block's own logic
  `RNP_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push, !qstat.full)
  `RNP_ASSERT_IMP(a_end_is_last, clk_i, rst_ni, out_o.valid && out_o.packet_end,
                  out_o.run_last)
  `RNP_ASSERT_IMP(a_start_not_last, clk_i, rst_ni, out_o.valid && out_o.packet_start,
                  !out_o.run_last)
  `RNP_ASSERT_NXT(a_drain_idle, clk_i, rst_ni,
                  out_o.valid && out_o.ready && qstat.empty, !out_o.valid)

endmodule

>>> tb/rtp_nalu_packetizer_unit_test.sv
// self-checking bench for the rtp nalu packetizer: random and directed unit bytes in,
// framed rtp-over-tcp byte stream checked against an in-bench packetizer model
// depends on rnp_pkg, rnp_if and rtp_nalu_packetizer_unit
`timescale 1ns / 1ps

module rtp_nalu_packetizer_unit_test;
  import rnp_pkg::*;

  // idling profiles
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  // codec mode 3 is not named in the package; it behaves as audio
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // rtp and fragmentation constants
  localparam logic [7:0] RTP_V2_BYTE   = 8'h80;
  localparam logic [7:0] FUA_TYPE      = 8'd28;
  localparam logic [5:0] H265_FU_TYPE  = 6'd49;
  localparam logic [7:0] FU_S_BIT      = 8'h80;
  localparam logic [7:0] FU_E_BIT      = 8'h40;
  localparam logic [14:0] MAX_PAY_FLOOR = 15'd16;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        unit_first;
    logic [15:0] unit_length;
    logic [31:0] media_time;
  } nal_byte_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       run_last;
  } rtp_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // apb port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // channel drive values
  logic      drv_valid = 1'b0;
  nal_byte_t drv_item = '0;
  logic      rtp_ready = 1'b0;
  logic      in_taken = 1'b0;
  logic      hold_on = 1'b0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  rnp_in_if  nal_bus ();
  rnp_out_if rtp_bus ();

  assign nal_bus.valid       = drv_valid;
  assign nal_bus.data_byte   = drv_item.data_byte;
  assign nal_bus.unit_first  = drv_item.unit_first;
  assign nal_bus.unit_length = drv_item.unit_length;
  assign nal_bus.media_time  = drv_item.media_time;
  assign rtp_bus.ready       = rtp_ready;

  rtp_nalu_packetizer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (nal_bus),
    .out_o   (rtp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // stimulus and expectation stores
  nal_byte_t nal_pending[$];
  rtp_byte_t rtp_expected[$];
  rtp_byte_t pkt_stage[$];
  int unsigned nal_queued = 0;
  int unsigned nal_accepted = 0;
  int unsigned mismatch_count = 0;

  // configuration copy
  logic [1:0]  cfg_codec = CODEC_MODE_RST;
  logic [6:0]  cfg_ptype = PTYPE_RST;
  logic [31:0] cfg_source_id = '0;
  logic [14:0] cfg_mtu = MTU_RST;

  // packetizer state
  logic [15:0] seq_num = '0;
  logic [15:0] held_hdr = '0;
  logic [31:0] held_ts = '0;
  logic [15:0] unit_left = '0;
  logic [15:0] frag_left = '0;
  logic        in_frag = 1'b0;
  logic        first_frag = 1'b1;
  logic [1:0]  unit_codec = MODE_H264;
  logic [15:0] frag_cap = '0;
  logic        hdr_wait = 1'b0;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic stage_byte(input logic [7:0] b, input logic start, input logic stop);
    rtp_byte_t e;
    e.out_byte = b;
    e.packet_start = start;
    e.packet_end = stop;
    e.run_last = 1'b0;
    pkt_stage.push_back(e);
  endtask

  // length prefix plus 12-byte rtp header, bumps the sequence number
  task automatic stage_rtp_head(input logic [31:0] rtp_len, input logic marker);
    stage_byte(rtp_len[15:8], 1'b1, 1'b0);
    stage_byte(rtp_len[7:0], 1'b0, 1'b0);
    stage_byte(RTP_V2_BYTE, 1'b0, 1'b0);
    stage_byte({marker, cfg_ptype}, 1'b0, 1'b0);
    stage_byte(seq_num[15:8], 1'b0, 1'b0);
    stage_byte(seq_num[7:0], 1'b0, 1'b0);
    stage_byte(held_ts[31:24], 1'b0, 1'b0);
    stage_byte(held_ts[23:16], 1'b0, 1'b0);
    stage_byte(held_ts[15:8], 1'b0, 1'b0);
    stage_byte(held_ts[7:0], 1'b0, 1'b0);
    stage_byte(cfg_source_id[31:24], 1'b0, 1'b0);
    stage_byte(cfg_source_id[23:16], 1'b0, 1'b0);
    stage_byte(cfg_source_id[15:8], 1'b0, 1'b0);
    stage_byte(cfg_source_id[7:0], 1'b0, 1'b0);
    seq_num = seq_num + 16'd1;
  endtask

  // works out the stream bytes caused by one accepted unit byte
  task automatic packetize_byte(input nal_byte_t it);
    logic [1:0]  m;
    logic [15:0] mp;
    logic [15:0] minlen;
    logic [15:0] left;
    logic [15:0] frag;
    logic        last;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [7:0]  fu;
    rtp_byte_t   e;
    pkt_stage.delete();
    if (it.unit_first) begin
      m = (cfg_codec >= MODE_AUDIO) ? MODE_AUDIO : cfg_codec;
      mp = (cfg_mtu < MAX_PAY_FLOOR) ? {1'b0, MAX_PAY_FLOOR} : {1'b0, cfg_mtu};
      minlen = (m == MODE_H265) ? 16'd2 : 16'd1;
      frag_left = '0;
      in_frag = 1'b0;
      hdr_wait = 1'b0;
      first_frag = 1'b1;
      if (it.unit_length < minlen) begin
        // short unit is dropped
        unit_left = '0;
      end else begin
        unit_codec = m;
        held_ts = it.media_time;
        unit_left = it.unit_length - 16'd1;
        if (m == MODE_AUDIO || it.unit_length <= mp) begin
          stage_rtp_head(32'd12 + {16'd0, it.unit_length}, 1'b1);
          stage_byte(it.data_byte, 1'b0, unit_left == 16'd0);
        end else begin
          in_frag = 1'b1;
          held_hdr = {it.data_byte, 8'h00};
          hdr_wait = (m == MODE_H265);
          frag_cap = mp - ((m == MODE_H265) ? 16'd3 : 16'd2);
        end
      end
    end else if (unit_left != 16'd0) begin
      left = unit_left;
      unit_left = left - 16'd1;
      if (!in_frag) begin
        stage_byte(it.data_byte, 1'b0, unit_left == 16'd0);
      end else if (hdr_wait) begin
        held_hdr = held_hdr | {8'h00, it.data_byte};
        hdr_wait = 1'b0;
      end else if (frag_left == 16'd0) begin
        // open a new fragment
        frag = (left < frag_cap) ? left : frag_cap;
        last = (frag == left);
        h0 = held_hdr[15:8];
        h1 = held_hdr[7:0];
        fu = (first_frag ? FU_S_BIT : 8'h00) | (last ? FU_E_BIT : 8'h00);
        if (unit_codec == MODE_H265) begin
          stage_rtp_head(32'd15 + {16'd0, frag}, last);
          stage_byte({h0[7], H265_FU_TYPE, h0[0]}, 1'b0, 1'b0);
          stage_byte(h1, 1'b0, 1'b0);
          stage_byte({fu[7:6], h0[6:1]}, 1'b0, 1'b0);
        end else begin
          stage_rtp_head(32'd14 + {16'd0, frag}, last);
          stage_byte({h0[7:5], 5'd0} | FUA_TYPE, 1'b0, 1'b0);
          stage_byte({fu[7:6], 1'b0, h0[4:0]}, 1'b0, 1'b0);
        end
        first_frag = 1'b0;
        frag_left = frag - 16'd1;
        stage_byte(it.data_byte, 1'b0, frag_left == 16'd0);
      end else begin
        frag_left = frag_left - 16'd1;
        stage_byte(it.data_byte, 1'b0, frag_left == 16'd0);
      end
    end
    for (int i = 0; i < pkt_stage.size(); i++) begin
      e = pkt_stage[i];
      e.run_last = (i == pkt_stage.size() - 1);
      rtp_expected.push_back(e);
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!drv_valid || in_taken)) begin
      if (nal_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item <= nal_pending.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // output ready driver
  always @(negedge clk_i) begin
    if (!rst_ni || hold_on) begin
      rtp_ready <= 1'b0;
    end else begin
      rtp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin : check_rtp
    nal_byte_t it;
    rtp_byte_t want;
    rtp_byte_t got;
    in_taken <= rst_ni && nal_bus.valid && nal_bus.ready;
    if (rst_ni && nal_bus.valid && nal_bus.ready) begin
      it.data_byte = nal_bus.data_byte;
      it.unit_first = nal_bus.unit_first;
      it.unit_length = nal_bus.unit_length;
      it.media_time = nal_bus.media_time;
      packetize_byte(it);
      nal_accepted <= nal_accepted + 1;
    end
    if (rst_ni && rtp_bus.valid && rtp_bus.ready) begin
      got.out_byte = rtp_bus.out_byte;
      got.packet_start = rtp_bus.packet_start;
      got.packet_end = rtp_bus.packet_end;
      got.run_last = rtp_bus.run_last;
      if (rtp_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected transfer: byte %h start %b end %b last %b",
                   got.out_byte, got.packet_start, got.packet_end, got.run_last);
      end else begin
        want = rtp_expected.pop_front();
        if (want.out_byte !== got.out_byte || want.packet_start !== got.packet_start ||
            want.packet_end !== got.packet_end || want.run_last !== got.run_last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at %0t: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                     $realtime, want.out_byte, want.packet_start, want.packet_end,
                     want.run_last, got.out_byte, got.packet_start, got.packet_end,
                     got.run_last);
        end
      end
    end
  end

  // apb write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CODEC_MODE: cfg_codec = val[1:0];
      REG_PTYPE:      cfg_ptype = val[6:0];
      REG_SOURCE_ID:  cfg_source_id = val;
      REG_MTU:        cfg_mtu = val[14:0];
      default: ;
    endcase
  endtask

  task automatic queue_nal(input logic [7:0] b, input logic first, input logic [15:0] len,
                           input logic [31:0] ts);
    nal_byte_t it;
    it.data_byte = b;
    it.unit_first = first;
    it.unit_length = len;
    it.media_time = ts;
    nal_pending.push_back(it);
    nal_queued++;
  endtask

  // first byte carries length and timestamp; followers carry noise there
  task automatic queue_unit(input logic [15:0] len, input int unsigned nbytes,
                            input logic [31:0] ts, input logic [7:0] b0);
    queue_nal(b0, 1'b1, len, ts);
    for (int unsigned i = 1; i < nbytes; i++)
      queue_nal(8'($urandom), 1'b0, 16'($urandom), $urandom);
  endtask

  // mostly whole units, some truncated, dropped, oversized or stray
  task automatic queue_random_units(input int unsigned n_items);
    int unsigned goal;
    int unsigned r;
    int unsigned len;
    goal = nal_queued + n_items;
    while (nal_queued < goal) begin
      r = $urandom_range(99);
      if (r < 3) begin
        queue_nal(8'($urandom), 1'b0, 16'($urandom), $urandom);
      end else if (r < 6) begin
        queue_unit(16'd0, $urandom_range(1, 3), $urandom, 8'($urandom));
      end else if (r < 9) begin
        len = $urandom_range(1000, 65535);
        queue_unit(16'(len), $urandom_range(1, 20), $urandom, 8'($urandom));
      end else if (r < 20) begin
        len = $urandom_range(2, 50);
        queue_unit(16'(len), $urandom_range(1, len - 1), $urandom, 8'($urandom));
      end else begin
        len = (r < 28) ? $urandom_range(1, 3) : $urandom_range(1, 50);
        queue_unit(16'(len), len, $urandom, 8'($urandom));
      end
    end
  endtask

  task automatic set_idling(input int mode);
    send_idle_pct = (mode == IDLE_SEND) ? 66 : (mode == IDLE_BOTH) ? 17 : 0;
    stall_pct = (mode == IDLE_RECV) ? 66 : (mode == IDLE_BOTH) ? 17 : 0;
  endtask

  // wait until every transfer is taken and answered, then let the pipe settle
  task automatic drain_all();
    while (nal_accepted != nal_queued) @(negedge clk_i);
    while (rtp_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_all(input logic [1:0] codec, input logic [6:0] pt,
                           input logic [31:0] ssrc, input logic [14:0] maxpay);
    apb_write(REG_CODEC_MODE, {30'd0, codec});
    apb_write(REG_PTYPE, {25'd0, pt});
    apb_write(REG_SOURCE_ID, ssrc);
    apb_write(REG_MTU, {17'd0, maxpay});
  endtask

  task automatic run_phase(input logic [1:0] codec, input logic [6:0] pt,
                           input logic [31:0] ssrc, input logic [14:0] maxpay,
                           input int mode, input int unsigned n_items, input logic pressure);
    write_all(codec, pt, ssrc, maxpay);
    set_idling(mode);
    queue_random_units(n_items);
    if (pressure) begin
      // receiver holds off while the sender keeps offering
      @(negedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_on <= 1'b0;
    end
    drain_all();
  endtask

  // run limit
  initial begin
    #400000;
    $display("rtp_nalu_packetizer_unit_test: done, errors");
    $finish;
  end

  // main sequence
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings, stray byte, empty unit, extremes, abandoned fragment
    set_idling(IDLE_NONE);
    queue_nal(8'h00, 1'b0, 16'h0000, 32'h0000_0000);
    queue_unit(16'd0, 2, $urandom, 8'($urandom));
    queue_unit(16'd1, 1, 32'hFFFF_FFFF, 8'hFF);
    queue_unit(16'd3, 3, 32'h0000_0000, 8'h00);
    queue_unit(16'hFFFF, 3, $urandom, 8'($urandom));
    queue_unit(16'd2, 2, $urandom, 8'($urandom));
    drain_all();

    // directed: h265 short unit, then a two-fragment unit at the smallest size
    write_all(MODE_H265, 7'd127, 32'hFFFF_FFFF, 15'd16);
    queue_unit(16'd1, 1, $urandom, 8'($urandom));
    queue_unit(16'd18, 18, $urandom, 8'($urandom));
    drain_all();

    // random phases over codec modes, sizes and idling profiles
    run_phase(MODE_H264, 7'($urandom), $urandom, 15'd16, IDLE_NONE, 60, 1'b0);
    run_phase(MODE_H265, 7'($urandom), $urandom, 15'($urandom_range(17, 40)),
              IDLE_SEND, 60, 1'b0);
    run_phase(MODE_AUDIO, 7'd0, 32'd0, 15'd0, IDLE_RECV, 50, 1'b0);
    run_phase(MODE_SPARE, 7'($urandom), $urandom, 15'd5, IDLE_BOTH, 50, 1'b0);
    run_phase(MODE_H264, 7'd127, 32'hFFFF_FFFF, 15'($urandom_range(16, 24)),
              IDLE_RECV, 60, 1'b1);
    run_phase(MODE_H265, 7'($urandom), $urandom, 15'h7FFF, IDLE_NONE, 40, 1'b0);
    run_phase(MODE_H264, 7'($urandom), $urandom, 15'd16384, IDLE_BOTH, 40, 1'b0);
    run_phase(MODE_H265, 7'($urandom), $urandom, 15'd16, IDLE_BOTH, 60, 1'b0);

    if (rtp_expected.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0) begin
      $display("rtp_nalu_packetizer_unit_test: done, clean");
    end else begin
      $display("rtp_nalu_packetizer_unit_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rnp_pkg.sv
hdl/rnp_if.sv
hdl/rnp_front.sv
hdl/rnp_queue.sv
hdl/rnp_back.sv
hdl/rtp_nalu_packetizer_unit.sv
tb/rtp_nalu_packetizer_unit_test.sv
